[sv/pft_pkg.sv]
`default_nettype none

package pft_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 128;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] START_CHAR_RESET  = 8'd2;
    localparam logic [7:0] END_CHAR_RESET    = 8'd3;
    localparam logic [7:0] ESCAPE_CHAR_RESET = 8'd27;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    localparam logic [1:0] CFG_START_CHAR  = 2'd0;
    localparam logic [1:0] CFG_END_CHAR    = 2'd1;
    localparam logic [1:0] CFG_ESCAPE_CHAR = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] flags;
        logic [7:0] command;
        logic [7:0] sequence_req;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       error;
    } result_t;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] value;
    } cfg_write_t;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] end_char;
        logic [7:0] escape_char;
    } cfg_regs_t;

    typedef enum logic [1:0] {
        SYM_START = 2'd0,
        SYM_DATA  = 2'd1,
        SYM_END   = 2'd2,
        SYM_ERROR = 2'd3
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t  kind;
        logic [7:0] value;
        logic       last;
    } sym_t;

endpackage

`default_nettype wire

[sv/pft_stream_if.sv]
`default_nettype none

interface pft_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/pft_fifo.sv]
`default_nettype none

module pft_fifo #(
    parameter int DEPTH = pft_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pft_pkg::sym_t push_sym,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output pft_pkg::sym_t      head_sym
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pft_pkg::sym_t mem_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_sym   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_sym;
        end
    end

endmodule

`default_nettype wire

[sv/pft_front.sv]
`default_nettype none

module pft_front #(
    parameter int MAX_PAYLOAD = pft_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pft_stream_if.sink    item,
    output logic          push,
    output pft_pkg::sym_t push_sym,
    input  wire logic     full
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    typedef enum logic [8:0] {
        ST_ACCEPT = 9'b000000001,
        ST_FLAGS  = 9'b000000010,
        ST_CMD    = 9'b000000100,
        ST_SEQ    = 9'b000001000,
        ST_LEN    = 9'b000010000,
        ST_PAD    = 9'b000100000,
        ST_SUML   = 9'b001000000,
        ST_SUMH   = 9'b010000000,
        ST_END    = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic        in_packet_reg, in_packet_next;
    logic [7:0]  remaining_reg, remaining_next;
    logic [15:0] sum_reg, sum_next;
    logic        odd_reg, odd_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  command_reg, command_next;
    logic [7:0]  sequence_reg, sequence_next;
    logic [7:0]  length_reg, length_next;

    pft_pkg::item_t in_item;
    logic           accept;

    assign in_item    = item.payload;
    assign item.ready = (state_reg == ST_ACCEPT) && !full;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        state_next     = state_reg;
        in_packet_next = in_packet_reg;
        remaining_next = remaining_reg;
        sum_next       = sum_reg;
        odd_next       = odd_reg;
        flags_next     = flags_reg;
        command_next   = command_reg;
        sequence_next  = sequence_reg;
        length_next    = length_reg;
        push           = 1'b0;
        push_sym       = '{kind: pft_pkg::SYM_DATA, value: 8'd0, last: 1'b0};

        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (accept)
                begin
                    if (in_item.opcode == pft_pkg::OP_START)
                    begin
                        in_packet_next = 1'b0;
                        remaining_next = 8'd0;
                        sum_next       = 16'd0;
                        push           = 1'b1;
                        if (in_item.payload_length > MAX_LEN)
                        begin
                            odd_next = 1'b0;
                            push_sym = '{kind: pft_pkg::SYM_ERROR, value: 8'd0, last: 1'b1};
                        end
                        else
                        begin
                            odd_next      = in_item.payload_length[0];
                            flags_next    = in_item.flags;
                            command_next  = in_item.command;
                            sequence_next = in_item.sequence_req;
                            length_next   = in_item.payload_length;
                            push_sym      = '{kind: pft_pkg::SYM_START, value: 8'd0,
                                              last: 1'b0};
                            state_next    = ST_FLAGS;
                        end
                    end
                    else if (in_packet_reg)
                    begin
                        push           = 1'b1;
                        push_sym       = '{kind: pft_pkg::SYM_DATA, value: in_item.data_byte,
                                           last: (remaining_reg != 8'd1)};
                        sum_next       = sum_reg + {8'd0, in_item.data_byte};
                        remaining_next = remaining_reg - 8'd1;
                        if (remaining_reg == 8'd1)
                        begin
                            in_packet_next = 1'b0;
                            state_next     = odd_reg ? ST_PAD : ST_SUML;
                        end
                    end
                end
            end
            ST_FLAGS:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    push_sym   = '{kind: pft_pkg::SYM_DATA, value: flags_reg, last: 1'b0};
                    sum_next   = sum_reg + {8'd0, flags_reg};
                    state_next = ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    push_sym   = '{kind: pft_pkg::SYM_DATA, value: command_reg, last: 1'b0};
                    sum_next   = sum_reg + {8'd0, command_reg};
                    state_next = ST_SEQ;
                end
            end
            ST_SEQ:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    push_sym   = '{kind: pft_pkg::SYM_DATA, value: sequence_reg, last: 1'b0};
                    sum_next   = sum_reg + {8'd0, sequence_reg};
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (!full)
                begin
                    push     = 1'b1;
                    push_sym = '{kind: pft_pkg::SYM_DATA, value: length_reg,
                                 last: (length_reg != 8'd0)};
                    sum_next = sum_reg + {8'd0, length_reg};
                    if (length_reg == 8'd0)
                    begin
                        state_next = ST_SUML;
                    end
                    else
                    begin
                        in_packet_next = 1'b1;
                        remaining_next = length_reg;
                        state_next     = ST_ACCEPT;
                    end
                end
            end
            ST_PAD:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    push_sym   = '{kind: pft_pkg::SYM_DATA, value: 8'd0, last: 1'b0};
                    state_next = ST_SUML;
                end
            end
            ST_SUML:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    push_sym   = '{kind: pft_pkg::SYM_DATA, value: sum_reg[7:0], last: 1'b0};
                    state_next = ST_SUMH;
                end
            end
            ST_SUMH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    push_sym   = '{kind: pft_pkg::SYM_DATA, value: sum_reg[15:8], last: 1'b0};
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                if (!full)
                begin
                    push           = 1'b1;
                    push_sym       = '{kind: pft_pkg::SYM_END, value: 8'd0, last: 1'b1};
                    in_packet_next = 1'b0;
                    remaining_next = 8'd0;
                    odd_next       = 1'b0;
                    state_next     = ST_ACCEPT;
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            in_packet_reg <= 1'b0;
            remaining_reg <= 8'd0;
            sum_reg       <= 16'd0;
            odd_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_packet_reg <= in_packet_next;
            remaining_reg <= remaining_next;
            sum_reg       <= sum_next;
            odd_reg       <= odd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flags_reg    <= flags_next;
        command_reg  <= command_next;
        sequence_reg <= sequence_next;
        length_reg   <= length_next;
    end

endmodule

`default_nettype wire

[sv/pft_back.sv]
`default_nettype none

module pft_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pft_pkg::cfg_regs_t chars,
    input  wire logic               head_valid,
    input  wire pft_pkg::sym_t      head_sym,
    output logic                    pop,
    pft_stream_if.source            result
);

    logic             out_valid_reg, out_valid_next;
    pft_pkg::result_t out_reg, out_next;
    logic             esc_sent_reg, esc_sent_next;

    logic can_load;
    logic special;

    assign can_load = !out_valid_reg || result.ready;
    assign special  = (head_sym.kind == pft_pkg::SYM_DATA) &&
                      ((head_sym.value == chars.start_char) ||
                       (head_sym.value == chars.end_char) ||
                       (head_sym.value == chars.escape_char));

    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        esc_sent_next  = esc_sent_reg;
        pop            = 1'b0;

        if (can_load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                if (special && !esc_sent_reg)
                begin
                    out_next      = '{tx_byte: chars.escape_char, last_byte: 1'b0,
                                      error: 1'b0};
                    esc_sent_next = 1'b1;
                end
                else
                begin
                    pop           = 1'b1;
                    esc_sent_next = 1'b0;
                    unique case (head_sym.kind)
                        pft_pkg::SYM_START:
                            out_next = '{tx_byte: chars.start_char, last_byte: head_sym.last,
                                         error: 1'b0};
                        pft_pkg::SYM_END:
                            out_next = '{tx_byte: chars.end_char, last_byte: head_sym.last,
                                         error: 1'b0};
                        pft_pkg::SYM_ERROR:
                            out_next = '{tx_byte: 8'd0, last_byte: 1'b1, error: 1'b1};
                        default:
                            out_next = '{tx_byte: head_sym.value, last_byte: head_sym.last,
                                         error: 1'b0};
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            esc_sent_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            esc_sent_reg  <= esc_sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

[sv/packet_framer_tx.sv]
// Transmit framer with byte stuffing and a 16-bit additive checksum.
// The item channel takes words: a start word carries the four header bytes,
// and each payload word carries one data byte. The result channel gives one
// line byte per word, with last_byte marking the final byte caused by an
// input word and error marking the single result of an oversized length.
// The cfg channel writes the start, end and escape characters and is always
// ready. Write it only while the block is idle; the block does not check.
// A front sequencer turns each input word into symbols in a small queue, one
// symbol per cycle while the queue is not full; a back stage expands each
// symbol into one or two line bytes through a registered output, one byte
// per cycle while the receiver is ready. The first byte for an accepted word
// passes through the queue and then the output register before it is valid.
// The front pushes a payload word's symbol as it accepts the word, so the
// sustained rate is set by the output register; an escaped byte goes out as
// two bytes. A start word then walks the flags, command, sequence and length
// states; a trailer adds pad (odd length), sum low, sum high and end states.
// Reset restores the default characters and leaves the block idle.
// When the receiver stalls the output holds, the queue fills and the item
// channel then deasserts ready; no word is lost.
`default_nettype none

module packet_framer_tx #(
    parameter int MAX_PAYLOAD = pft_pkg::MAX_PAYLOAD_DEFAULT,
    parameter int QUEUE_DEPTH = pft_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    pft_stream_if.sink   item,
    pft_stream_if.source result,
    pft_stream_if.sink   cfg
);

    pft_pkg::cfg_regs_t  cfg_reg, cfg_next;
    pft_pkg::cfg_write_t cfg_word;

    logic          push;
    pft_pkg::sym_t push_sym;
    logic          full;
    logic          pop;
    logic          head_valid;
    pft_pkg::sym_t head_sym;

    assign cfg.ready = 1'b1;
    assign cfg_word  = cfg.payload;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_word.index)
                pft_pkg::CFG_START_CHAR:  cfg_next.start_char  = cfg_word.value;
                pft_pkg::CFG_END_CHAR:    cfg_next.end_char    = cfg_word.value;
                pft_pkg::CFG_ESCAPE_CHAR: cfg_next.escape_char = cfg_word.value;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{start_char: pft_pkg::START_CHAR_RESET,
                         end_char: pft_pkg::END_CHAR_RESET,
                         escape_char: pft_pkg::ESCAPE_CHAR_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pft_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .push     (push),
        .push_sym (push_sym),
        .full     (full)
    );

    pft_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_sym   (push_sym),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_sym   (head_sym)
    );

    pft_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (cfg_reg),
        .head_valid (head_valid),
        .head_sym   (head_sym),
        .pop        (pop),
        .result     (result)
    );

endmodule

`default_nettype wire
